// ===== hw/rtl/assert_macros.svh =====
// assertion macros, included by stage2_table_walker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked every cycle outside reset
`define STW_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// consequent checked in the cycle after the antecedent
`define STW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define STW_ASSERT(lbl, clk, rst, prop, msg)
`define STW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/stw_pkg.sv =====
package stw_pkg;

  // walker command on the request channel
  typedef enum logic {
    ACT_TRANSLATE = 1'b0,
    ACT_WRITE     = 1'b1
  } action_t;

  // walk outcome
  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_TOO_WIDE = 3'd1,
    STAT_NO_TABLE = 3'd2,
    STAT_INVALID  = 3'd3,
    STAT_RESERVED = 3'd4
  } status_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ROOT_BASE      = 2'd0,
    REG_START_LEVEL    = 2'd1,
    REG_CONCAT_ORDER   = 2'd2,
    REG_TABLES_PRESENT = 2'd3
  } cfg_reg_t;

  // walk sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_FINISH
  } state_t;

  localparam logic [1:0] LAST_LEVEL = 2'd3;

  typedef struct packed {
    action_t     action;
    logic [63:0] in_address;
    logic [11:0] desc_slot;
    logic [63:0] desc_word;
  } req_item_t;

  typedef struct packed {
    logic [47:0] out_address;
    status_t     status;
    logic [1:0]  final_level;
  } rsp_item_t;

  // widest index field of a level (9 bits plus up to 3 concatenation bits)
  function automatic logic [11:0] level_index(input logic [63:0] a, input logic [1:0] lvl);
    logic [11:0] r;
    case (lvl)
      2'd0:    r = a[50:39];
      2'd1:    r = a[41:30];
      2'd2:    r = a[32:21];
      default: r = a[23:12];
    endcase
    return r;
  endfunction

  // address bits passed through from the input at a given level
  function automatic logic [63:0] level_offset_mask(input logic [1:0] lvl);
    logic [63:0] r;
    case (lvl)
      2'd0:    r = 64'h0000_007F_FFFF_FFFF;
      2'd1:    r = 64'h0000_0000_3FFF_FFFF;
      2'd2:    r = 64'h0000_0000_001F_FFFF;
      default: r = 64'h0000_0000_0000_0FFF;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/stw_if.sv =====
// request channel
interface stw_req_if import stw_pkg::*; ();
  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// response channel
interface stw_rsp_if import stw_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/stw_ram.sv =====
module stw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/stage2_table_walker.sv =====
// channel  dir  payload                                   transfer when
// req      in   action, in_address, desc_slot, desc_word  req.valid & req.ready
// rsp      out  out_address, status, final_level          rsp.valid & rsp.ready
// cfg      in   cfg_index, cfg_data                       cfg_we
//
// after reset the store is zeroed one word a cycle in S_CLEAR, with req.ready low;
// configuration writes are taken meanwhile.
// a write or an early fault goes from S_IDLE to S_FINISH; a translation passes S_READ (ram
// read) and S_CHECK (decode) for each level walked, then S_FINISH, which loads the result
// register once it is free. req.ready is high only between items;
// the result register lets the next item start while the previous result waits on rsp.ready.
`include "assert_macros.svh"

module stage2_table_walker import stw_pkg::*; #(
  parameter int STORE_WORDS = 4096,
  parameter int PHYS_BITS   = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  stw_req_if.sink     req,
  stw_rsp_if.source   rsp
);

  // STORE_WORDS is to be a power of two, which the block does not enforce, so word addresses wrap by truncation
  localparam int AW = $clog2(STORE_WORDS);
  localparam logic [AW-1:0] LAST_WORD = AW'(STORE_WORDS - 1);
  localparam logic [AW-1:0] PAGE_WORD_MASK = ~AW'(511);
  localparam logic [63:0] PMASK = (64'h1 << PHYS_BITS) - 64'h1;

  // configuration registers
  logic [47:0] root_table_base;
  logic [1:0]  root_start_level;
  logic [1:0]  root_concat_order;
  logic        tables_present;

  // sequencer and walk registers
  state_t                state, state_next;
  logic [AW-1:0]         clr_idx;
  logic [1:0]            level;
  logic [PHYS_BITS-1:0]  ipa;
  logic [AW-1:0]         tbl_word;
  logic [47:0]           res_addr;
  status_t               res_status;
  logic [1:0]            res_level;

  // ram port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [63:0]   desc;

  // decode helpers
  logic          accept;
  logic          rsp_free;
  logic          rsp_load;
  logic          too_wide;
  logic [63:0]   ipa_ext;
  logic [11:0]   idx_raw;
  logic [11:0]   idx_mask;
  logic [63:0]   off_mask;
  logic [63:0]   blk_addr;

  stw_ram #(
    .WIDTH (64),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (desc)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      root_table_base   <= '0;
      root_start_level  <= 2'd1;
      root_concat_order <= 2'd0;
      tables_present    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROOT_BASE:      root_table_base   <= cfg_data;
        REG_START_LEVEL:    root_start_level  <= cfg_data[1:0];
        REG_CONCAT_ORDER:   root_concat_order <= cfg_data[1:0];
        REG_TABLES_PRESENT: tables_present    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake terms, width check and shared level decode: index field and mask, offset mask, block address
  assign accept   = req.valid && req.ready;
  assign rsp_free = !rsp.valid || rsp.ready;
  assign too_wide = (req.data.in_address & ~PMASK) != 64'h0;
  assign ipa_ext  = 64'(ipa);
  assign idx_raw  = level_index(ipa_ext, level);
  assign idx_mask = (level == root_start_level) ?
                    12'((13'h200 << root_concat_order) - 13'd1) : 12'h1ff;
  assign off_mask = level_offset_mask(level);
  assign blk_addr = (desc & PMASK & ~off_mask) | (ipa_ext & off_mask);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == LAST_WORD) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (req.data.action == ACT_WRITE || too_wide || !tables_present) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: state_next = S_CHECK;
      S_CHECK: begin
        if (desc[0] && desc[1] && level != LAST_LEVEL) begin
          state_next = S_READ;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (rsp_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req.ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_idx;
    ram_wdata = 64'h0;
    rsp_load  = 1'b0;
    ram_raddr = tbl_word + AW'(idx_raw & idx_mask);
    case (state)
      S_CLEAR: ram_we = 1'b1;
      S_IDLE: begin
        req.ready = 1'b1;
        if (accept && req.data.action == ACT_WRITE) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(req.data.desc_slot);
          ram_wdata = req.data.desc_word;
        end
      end
      S_FINISH: rsp_load = rsp_free;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + AW'(1);
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          ipa       <= PHYS_BITS'(req.data.in_address);
          level     <= root_start_level;
          tbl_word  <= AW'(root_table_base >> 3) & PAGE_WORD_MASK;
          res_addr  <= '0;
          res_level <= 2'd0;
          if (req.data.action == ACT_WRITE) begin
            res_status <= STAT_OK;
          end else if (too_wide) begin
            res_status <= STAT_TOO_WIDE;
          end else if (!tables_present) begin
            res_status <= STAT_NO_TABLE;
          end else begin
            res_status <= STAT_OK;
          end
        end
      end
      S_CHECK: begin
        res_level <= level;
        if (!desc[0]) begin
          res_status <= STAT_INVALID;
          res_addr   <= '0;
        end else if (!desc[1]) begin
          // block at levels 1 and 2; level-0 block and level-3 01 are reserved
          if (level == 2'd0 || level == LAST_LEVEL) begin
            res_status <= STAT_RESERVED;
            res_addr   <= '0;
          end else begin
            res_status <= STAT_OK;
            res_addr   <= blk_addr[47:0];
          end
        end else if (level == LAST_LEVEL) begin
          // page
          res_status <= STAT_OK;
          res_addr   <= blk_addr[47:0];
        end else begin
          // next-level table
          tbl_word <= AW'(desc >> 3) & PAGE_WORD_MASK;
          level    <= level + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rsp_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.data <= '{out_address: res_addr, status: res_status, final_level: res_level};
    end
  end

  // checks
  `STW_ASSERT(a_check_after_read, clk, rst, (state == S_CHECK) |-> ($past(state) == S_READ), "decode without a preceding read")
  `STW_ASSERT(a_level_steps, clk, rst, (state == S_READ && $past(state) == S_CHECK) |-> (level == $past(level) + 2'd1), "walk level did not advance by one")
  `STW_ASSERT(a_fault_zero_addr, clk, rst, (rsp.valid && rsp.data.status != STAT_OK) |-> (rsp.data.out_address == 48'h0), "faulting result carries an address")
  `STW_ASSERT_NEXT(a_write_done, clk, rst, accept && req.data.action == ACT_WRITE, state == S_FINISH && res_status == STAT_OK, "descriptor write did not complete directly")

endmodule

// ===== verif/tb_stage2_table_walker.sv =====
module tb_stage2_table_walker;
  import stw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_WORDS = 4096;
  localparam int PHYS_BITS   = 48;
  localparam logic [63:0] PMASK = (64'd1 << PHYS_BITS) - 64'd1;
  localparam logic [63:0] PAGE_OFFSET = 64'hFFF;

  // descriptor low bits
  localparam logic [1:0] DESC_BLOCK = 2'b01;
  localparam logic [1:0] DESC_TABLE = 2'b11;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [47:0] cfg_data;

  stw_req_if req_ch ();
  stw_rsp_if rsp_ch ();

  stage2_table_walker #(
    .STORE_WORDS(STORE_WORDS),
    .PHYS_BITS  (PHYS_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  // shadow of the descriptor store and the walker registers
  logic [63:0] desc_mem [STORE_WORDS] = '{default: '0};
  logic [47:0] cfg_root_base   = '0;
  logic [1:0]  cfg_start_level = 2'd1;
  logic [1:0]  cfg_concat      = 2'd0;
  logic        cfg_tables_on   = 1'b0;

  rsp_item_t walk_results_q [$];
  int        mismatch_count = 0;
  int        req_count = 0;
  int        write_count = 0;
  int        status_count [5] = '{default: 0};
  int        stop_level_count [4] = '{default: 0};

  // idling knobs: percent of requests (req) or of ready cycles (rsp) that start a gap, plus a hold-off length
  int req_gap_pct   = 0;
  int rsp_stall_pct = 0;
  int rsp_hold_cycles = 0;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog
  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d results still outstanding", $time, walk_results_q.size());
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = rand64();
    return v[47:0];
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  function automatic int level_shift(input int lvl);
    return 12 + 9 * (3 - lvl);
  endfunction

  // store word read at a level, root index widened by concatenation
  function automatic logic [11:0] walk_slot(input logic [63:0] tbl, input logic [63:0] ipa,
                                            input int lvl);
    logic [63:0] idx;
    logic [63:0] w;
    int ibits;
    ibits = 9 + ((lvl == int'(cfg_start_level)) ? int'(cfg_concat) : 0);
    idx = (ipa >> level_shift(lvl)) & ((64'd1 << ibits) - 64'd1);
    w = ((tbl >> 3) + idx) % STORE_WORDS;
    return w[11:0];
  endfunction

  // walker prediction, updates the shadow store on descriptor writes
  function automatic rsp_item_t predict_walk(input req_item_t it);
    rsp_item_t   r;
    logic [63:0] ipa;
    logic [63:0] tbl;
    logic [63:0] desc;
    logic [63:0] offmask;
    logic [63:0] pa;
    int          lvl;
    r = '0;
    r.status = STAT_OK;
    ipa = it.in_address;
    if (it.action == ACT_WRITE) begin
      desc_mem[it.desc_slot % STORE_WORDS] = it.desc_word;
      return r;
    end
    if ((ipa & ~PMASK) != 64'd0) begin
      r.status = STAT_TOO_WIDE;
      return r;
    end
    if (!cfg_tables_on) begin
      r.status = STAT_NO_TABLE;
      return r;
    end
    tbl = {16'd0, cfg_root_base} & PMASK & ~PAGE_OFFSET;
    for (lvl = int'(cfg_start_level); lvl <= int'(LAST_LEVEL); lvl++) begin
      offmask = (64'd1 << level_shift(lvl)) - 64'd1;
      desc = desc_mem[walk_slot(tbl, ipa, lvl)];
      r.final_level = lvl[1:0];
      if (!desc[0]) begin
        r.status = STAT_INVALID;
        return r;
      end
      // level-0 blocks and level-3 entries with low bits 01 are reserved
      if (desc[1:0] == DESC_BLOCK && (lvl == 0 || lvl == int'(LAST_LEVEL))) begin
        r.status = STAT_RESERVED;
        return r;
      end
      if (desc[1:0] == DESC_BLOCK || lvl == int'(LAST_LEVEL)) begin
        pa = ((desc & PMASK) & ~offmask) + (ipa & offmask);
        r.out_address = pa[47:0];
        return r;
      end
      tbl = desc & PMASK & ~PAGE_OFFSET;
    end
    r.status = STAT_INVALID;
    r.final_level = LAST_LEVEL;
    return r;
  endfunction

  // register write, only issued while the walker is idle
  task automatic write_reg(input cfg_reg_t idx, input logic [47:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_ROOT_BASE:      cfg_root_base   = value;
      REG_START_LEVEL:    cfg_start_level = value[1:0];
      REG_CONCAT_ORDER:   cfg_concat      = value[1:0];
      REG_TABLES_PRESENT: cfg_tables_on   = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_walker(input logic [47:0] base, input logic [1:0] start_lvl,
                            input logic [1:0] concat, input logic present);
    write_reg(REG_ROOT_BASE, base);
    write_reg(REG_START_LEVEL, {46'd0, start_lvl});
    write_reg(REG_CONCAT_ORDER, {46'd0, concat});
    write_reg(REG_TABLES_PRESENT, {47'd0, present});
  endtask

  // one request transfer, expectation queued when it is accepted
  task automatic send_req(input action_t act, input logic [63:0] addr,
                          input logic [11:0] slot, input logic [63:0] word);
    req_item_t it;
    rsp_item_t want;
    int        gap;
    it.action     = act;
    it.in_address = addr;
    it.desc_slot  = slot;
    it.desc_word  = word;
    gap = pick_gap(req_gap_pct);
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.data  <= it;
    do @(posedge clk); while (!req_ch.ready);
    want = predict_walk(it);
    walk_results_q.push_back(want);
    req_count++;
    if (act == ACT_WRITE) begin
      write_count++;
    end else begin
      status_count[int'(want.status)]++;
      stop_level_count[want.final_level]++;
    end
  endtask

  // drop valid and wait for every outstanding result
  task automatic wait_drained(input int settle);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (walk_results_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic [63:0] make_desc(input int lvl);
    logic [63:0] d;
    int          roll;
    d = rand64();
    roll = $urandom_range(99);
    if (roll < 8) d[0] = 1'b0;
    else if (roll < ((lvl == int'(LAST_LEVEL)) ? 16 : 30)) d[1:0] = DESC_BLOCK;
    else d[1:0] = DESC_TABLE;
    return d;
  endfunction

  // lay down descriptors along the path of a random address, then walk it
  task automatic build_and_walk();
    logic [63:0] ipa;
    logic [63:0] tbl;
    logic [63:0] d;
    int          lvl;
    bit          going;
    ipa = {16'd0, rand48()};
    tbl = {16'd0, cfg_root_base} & ~PAGE_OFFSET;
    going = 1'b1;
    lvl = int'(cfg_start_level);
    while (going && lvl <= int'(LAST_LEVEL)) begin
      d = make_desc(lvl);
      send_req(ACT_WRITE, rand64(), walk_slot(tbl, ipa, lvl), d);
      if (d[1:0] == DESC_TABLE && lvl < int'(LAST_LEVEL)) tbl = d & PMASK & ~PAGE_OFFSET;
      else going = 1'b0;
      lvl++;
    end
    send_req(ACT_TRANSLATE, ipa, 12'($urandom_range(4095)), rand64());
  endtask

  // unstructured transfer, any field value
  task automatic send_noise();
    logic [63:0] addr;
    addr = rand64();
    if ($urandom_range(1) == 1) addr[63:48] = '0;
    send_req(action_t'($urandom_range(1)), addr, 12'($urandom_range(4095)), rand64());
  endtask

  // descriptor writes and translations before any table exists, address width check first
  task automatic test_no_table();
    send_req(ACT_WRITE, 64'd0, 12'd4095, 64'hFFFF_FFFF_FFFF_FFFF);
    send_req(ACT_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 12'd0, 64'd0);
    send_req(ACT_TRANSLATE, 64'd0, 12'd0, 64'd0);
    send_req(ACT_TRANSLATE, 64'h0000_FFFF_FFFF_FFFF, 12'd0, 64'd0);
    send_req(ACT_TRANSLATE, 64'h0001_0000_0000_0000, 12'd0, 64'd0);
    send_req(ACT_TRANSLATE, 64'hFFFF_FFFF_FFFF_FFFF, 12'd0, 64'd0);
  endtask

  // hand-built tables: blocks, page, faults at each level, wrapped root
  task automatic test_directed_walks();
    wait_drained(16);
    set_walker(48'd0, 2'd1, 2'd0, 1'b1);
    // root at page 0, level-2 table at page 1, level-3 table at page 2
    send_req(ACT_WRITE, 64'd0, 12'd0, 64'hFFFF_FFFF_FFFF_FFFD);
    send_req(ACT_WRITE, 64'd0, 12'd1, 64'h0000_0000_0000_1003);
    send_req(ACT_WRITE, 64'd0, 12'd512, 64'h0000_ABCD_E020_0001);
    send_req(ACT_WRITE, 64'd0, 12'd513, 64'h0000_0000_0000_2003);
    send_req(ACT_WRITE, 64'd0, 12'd1024, 64'h0000_5555_6666_7003);
    send_req(ACT_WRITE, 64'd0, 12'd1025, 64'h8000_0000_0000_0001);
    send_req(ACT_TRANSLATE, 64'h0000_0000_3FFF_FFFF, 12'd0, 64'd0);
    send_req(ACT_TRANSLATE, 64'h0000_0000_401F_FFFF, 12'd0, 64'd0);
    send_req(ACT_TRANSLATE, 64'h0000_0000_4020_0ABC, 12'd0, 64'd0);
    send_req(ACT_TRANSLATE, 64'h0000_0000_4020_1ABC, 12'd0, 64'd0);
    send_req(ACT_TRANSLATE, 64'h0000_0000_4020_2000, 12'd0, 64'd0);
    send_req(ACT_TRANSLATE, 64'h0000_0000_4040_0000, 12'd0, 64'd0);
    send_req(ACT_TRANSLATE, 64'h0000_0000_8000_0000, 12'd0, 64'd0);
    // level-0 root: block there is reserved, table leads to a level-1 block
    wait_drained(16);
    set_walker(48'd0, 2'd0, 2'd0, 1'b1);
    send_req(ACT_TRANSLATE, 64'd0, 12'd0, 64'd0);
    send_req(ACT_TRANSLATE, 64'h0000_0080_0000_0000, 12'd0, 64'd0);
    // root at level 3 with the widest root index, last index wraps the store
    wait_drained(16);
    set_walker(48'h0000_0000_2000, 2'd3, 2'd3, 1'b1);
    send_req(ACT_TRANSLATE, 64'h0000_0000_0000_0123, 12'd0, 64'd0);
    send_req(ACT_TRANSLATE, 64'h0000_0000_00FF_F123, 12'd0, 64'd0);
  endtask

  // receiver holds off while requests keep coming, then the sender drains
  task automatic test_backpressure();
    wait_drained(16);
    set_walker(48'd0, 2'd1, 2'd1, 1'b1);
    req_gap_pct   = 0;
    rsp_stall_pct = 0;
    rsp_hold_cycles = 300;
    repeat (5) build_and_walk();
    wait_drained(0);
    rsp_hold_cycles = 0;
  endtask

  task automatic run_phase(input int n, input logic [47:0] base, input logic [1:0] start_lvl,
                           input logic [1:0] concat, input logic present,
                           input int req_pct, input int rsp_pct);
    int first;
    int roll;
    wait_drained(16);
    set_walker(base, start_lvl, concat, present);
    req_gap_pct   = req_pct;
    rsp_stall_pct = rsp_pct;
    first = req_count;
    while (req_count - first < n) begin
      roll = $urandom_range(99);
      if (roll < 3) wait_drained(0);
      else if (roll < 80) build_and_walk();
      else send_noise();
    end
  endtask

  // random walks over several register settings, extremes included
  task automatic test_random_phases();
    run_phase(110, 48'd0, 2'd1, 2'd0, 1'b1, 20, 20);
    run_phase(110, 48'hFFFF_FFFF_FFFF, 2'd0, 2'd3, 1'b1, 40, 40);
    run_phase(110, rand48(), 2'd2, 2'd1, 1'b1, 0, 0);
    run_phase(110, rand48(), 2'd3, 2'd2, 1'b1, 25, 10);
    run_phase(40, rand48(), 2'd0, 2'd0, 1'b0, 15, 15);
    run_phase(110, rand48(), 2'($urandom_range(3)), 2'($urandom_range(3)), 1'b1, 20, 30);
  endtask

  // response ready with random stalls and a counted hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold_cycles > 0) begin
        rsp_hold_cycles--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        stall_left = pick_gap(rsp_stall_pct);
        if (stall_left > 0) begin
          stall_left--;
          rsp_ch.ready <= 1'b0;
        end else begin
          rsp_ch.ready <= 1'b1;
        end
      end
    end
  end

  // compare each response transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    rsp_item_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (walk_results_q.size() == 0) begin
        $display("%0t: unexpected result, expected none got %0h/%0d/%0d", $time,
                 rsp_ch.data.out_address, rsp_ch.data.status, rsp_ch.data.final_level);
        mismatch_count++;
      end else begin
        want = walk_results_q.pop_front();
        if (rsp_ch.data.out_address !== want.out_address) begin
          $display("%0t: out_address expected %0h got %0h", $time,
                   want.out_address, rsp_ch.data.out_address);
          mismatch_count++;
        end
        if (rsp_ch.data.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status,
                   rsp_ch.data.status);
          mismatch_count++;
        end
        if (rsp_ch.data.final_level !== want.final_level) begin
          $display("%0t: final_level expected %0d got %0d", $time, want.final_level,
                   rsp_ch.data.final_level);
          mismatch_count++;
        end
      end
    end
  end

  // reset, tests in turn, verdict
  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = REG_ROOT_BASE;
    cfg_data     = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_no_table();
    test_directed_walks();
    test_backpressure();
    test_random_phases();
    wait_drained(20);

    $display("covered %0d transfers, %0d of them descriptor writes", req_count, write_count);
    $display("walks: ok %0d, too wide %0d, no table %0d, invalid %0d, reserved %0d; %s %0d/%0d/%0d/%0d",
             status_count[0], status_count[1], status_count[2], status_count[3],
             status_count[4], "stopped at levels 0-3:", stop_level_count[0],
             stop_level_count[1], stop_level_count[2], stop_level_count[3]);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
